@@ rtl/sequence_completion_tracker_assert.svh @@
// ----------------------------------------------------------------------------
// sequence completion tracker assertion macros
// shared property forms for the tracker's concurrent checks
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_COMPLETION_TRACKER_ASSERT_SVH
`define SEQUENCE_COMPLETION_TRACKER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SCT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequence completion tracker check failed");

// next-cycle implication, disabled while in reset
`define SCT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequence completion tracker check failed");

`endif

@@ rtl/sct_pkg.sv @@
// ----------------------------------------------------------------------------
// sct_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int WINDOW   = 64;
  localparam int WIN_BITS = $clog2(WINDOW);
  localparam int SEQ_W    = 64;
  localparam int TICK_W   = 32;

  typedef enum logic [1:0] {
    OP_ARRIVE = 2'd0,
    OP_TICK   = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IN_ORDER = 2'd0,
    ST_EARLY    = 2'd1,
    ST_STALE    = 2'd2,
    ST_DROPPED  = 2'd3
  } arr_status_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic drain;
    logic publish;
  } sct_cmd_t;

  typedef struct packed {
    logic go_drain;
    logic drain_more;
    logic done;
  } sct_stat_t;

endpackage

@@ rtl/sequence_completion_tracker.sv @@
// ----------------------------------------------------------------------------
// sequence_completion_tracker
// in-order completion tracking of out-of-order sequence numbers with a
// 64-entry early window, last-number completion and idle timeout
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   opcode, seq_num, is_last
// out       output     out_valid / out_stall complete, next_expected,
//                                            arrival_status, timed_out
// cfg       input      cfg_wr_en             cfg_wr_data (timeout_ticks)
//
// an item goes from transfer in to result through accept, execute and publish
// an arrival that advances the expected number then drains: it consumes the
// consecutive early entries and stops at the end of the run or at last
// one item in flight; the next transfer is taken while its result waits
// rst is synchronous and returns tracker state and timeout_ticks to reset values
// out_stall holds the result register; in_stall stays high until it is free
// ----------------------------------------------------------------------------
module sequence_completion_tracker import sct_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        opcode,
  input  logic [SEQ_W-1:0]  seq_num,
  input  logic              is_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              complete,
  output logic [SEQ_W-1:0]  next_expected,
  output logic [1:0]        arrival_status,
  output logic              timed_out,
  input  logic              cfg_wr_en,
  input  logic [TICK_W-1:0] cfg_wr_data
);

  sct_cmd_t  cmd;
  sct_stat_t stat;

  sct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sct_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .opcode         (opcode),
    .seq_num        (seq_num),
    .is_last        (is_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .complete       (complete),
    .next_expected  (next_expected),
    .arrival_status (arrival_status),
    .timed_out      (timed_out)
  );

`include "sequence_completion_tracker_assert.svh"

  // after a transfer in, no further item until this one is published
  `SCT_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // done only drops through a clear or a reset
  `SCT_ASSERT_IMP(a_done_sticky, clk, rst, $fell(stat.done),
                  $past(rst) || ($past(cmd.exec) && ($past(u_datapath.op_q) == OP_CLEAR)))

  // a timeout only comes from a tick, never with an arrival status
  `SCT_ASSERT_IMP(a_timeout_no_status, clk, rst, out_valid && timed_out,
                  arrival_status == ST_IN_ORDER)

endmodule

@@ rtl/sct_ctrl.sv @@
// ----------------------------------------------------------------------------
// sct_ctrl
// sequencing of load, execute, drain and publish steps plus output valid
// ----------------------------------------------------------------------------
module sct_ctrl import sct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  sct_stat_t stat,
  output sct_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_EXEC    = 4'b0010,
    S_DRAIN   = 4'b0100,
    S_PUBLISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.go_drain ? S_DRAIN : S_PUBLISH;
      end
      S_DRAIN: begin
        cmd.drain = 1'b1;
        if (!stat.drain_more) begin
          state_next = S_PUBLISH;
        end
      end
      S_PUBLISH: begin
        if (slot_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/sct_datapath.sv @@
// ----------------------------------------------------------------------------
// sct_datapath
// tracker state, window bitmap, idle counter and result register
// ----------------------------------------------------------------------------
module sct_datapath import sct_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  sct_cmd_t           cmd,
  output sct_stat_t          stat,
  input  logic [1:0]         opcode,
  input  logic [SEQ_W-1:0]   seq_num,
  input  logic               is_last,
  input  logic               cfg_wr_en,
  input  logic [TICK_W-1:0]  cfg_wr_data,
  output logic               complete,
  output logic [SEQ_W-1:0]   next_expected,
  output logic [1:0]         arrival_status,
  output logic               timed_out
);

  // latched item
  logic [1:0]        op_q;
  logic [SEQ_W-1:0]  seq_q;
  logic              last_q;

  // tracker state
  logic [TICK_W-1:0] timeout_ticks;
  logic [SEQ_W-1:0]  expected;
  logic [SEQ_W-1:0]  final_seq;
  logic              done;
  logic [WINDOW-1:0] bitmap;
  logic [TICK_W-1:0] idle_count;
  logic              fired;

  // per-item result bits held until publish
  arr_status_t       status_q;
  logic              fired_q;

  logic [SEQ_W-1:0]  final_eff;
  logic [SEQ_W-1:0]  offset;
  logic [TICK_W-1:0] idle_inc;
  logic              seq_eq;
  logic              seq_lt;
  logic              beyond;
  logic              at_final;

  // a last mark on this arrival counts before the compare
  assign final_eff = last_q ? seq_q : final_seq;
  assign seq_eq    = (seq_q == expected);
  assign seq_lt    = (seq_q < expected);
  assign offset    = seq_q - expected;
  assign beyond    = (offset[SEQ_W-1:WIN_BITS] != '0);
  assign at_final  = (expected == final_eff);
  assign idle_inc  = (idle_count == '1) ? idle_count : idle_count + 1'b1;

  assign stat.go_drain   = (opcode_t'(op_q) == OP_ARRIVE) && seq_eq && !at_final;
  assign stat.drain_more = bitmap[0] && (expected != final_seq);
  assign stat.done       = done;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= opcode;
      seq_q  <= seq_num;
      last_q <= is_last;
    end
    if (cmd.publish) begin
      complete       <= done;
      next_expected  <= expected;
      arrival_status <= status_q;
      timed_out      <= fired_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= '0;
      expected      <= '0;
      final_seq     <= '1;
      done          <= 1'b0;
      bitmap        <= '0;
      idle_count    <= '0;
      fired         <= 1'b0;
      status_q      <= ST_IN_ORDER;
      fired_q       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout_ticks <= cfg_wr_data;
      end
      if (cmd.exec) begin
        status_q <= ST_IN_ORDER;
        fired_q  <= 1'b0;
        case (op_q)
          OP_ARRIVE: begin
            idle_count <= '0;
            if (last_q) begin
              final_seq <= seq_q;
            end
            if (seq_eq) begin
              if (at_final) begin
                done <= 1'b1;
              end else begin
                expected <= expected + 1'b1;
                bitmap   <= bitmap >> 1;
              end
            end else if (seq_lt) begin
              status_q <= ST_STALE;
            end else if (beyond) begin
              status_q <= ST_DROPPED;
            end else begin
              bitmap[offset[WIN_BITS-1:0]] <= 1'b1;
              status_q                     <= ST_EARLY;
            end
          end
          OP_TICK: begin
            if ((timeout_ticks != '0) && !fired) begin
              idle_count <= idle_inc;
              if (idle_inc >= timeout_ticks) begin
                fired   <= 1'b1;
                fired_q <= 1'b1;
              end
            end
          end
          OP_CLEAR: begin
            expected   <= '0;
            final_seq  <= '1;
            done       <= 1'b0;
            bitmap     <= '0;
            idle_count <= '0;
            fired      <= 1'b0;
          end
          default: ;
        endcase
      end
      // one consecutive early entry consumed per cycle
      if (cmd.drain && bitmap[0]) begin
        if (expected == final_seq) begin
          done      <= 1'b1;
          bitmap[0] <= 1'b0;
        end else begin
          expected <= expected + 1'b1;
          bitmap   <= bitmap >> 1;
        end
      end
    end
  end

endmodule
